### rtl/fcdf_pkg.sv
`default_nettype none

package fcdf_pkg;

  localparam int unsigned MAX_TAPS    = 4096;
  localparam int unsigned TAP_AW      = $clog2(MAX_TAPS);
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned COEF_BITS   = 24;
  localparam int unsigned TAPCNT_W    = 12;
  localparam int unsigned DAMP_W      = 17;
  localparam int unsigned GAIN_W      = 21;
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 24;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 12'd1;
  localparam logic [DAMP_W-1:0]   DAMP_GAIN_RST = 17'd34359;
  localparam logic [DAMP_W-1:0]   DAMP_ONE      = 17'd65536;
  localparam logic [GAIN_W-1:0]   GAIN_RST      = 21'd131072;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_COEF   = 1'b1
  } func_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_TAP_COUNT     = 3'd0,
    CFG_DAMP_GAIN     = 3'd1,
    CFG_FEEDBACK_GAIN = 3'd2,
    CFG_LEFT_GAIN     = 3'd3,
    CFG_RIGHT_GAIN    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TAPCNT_W-1:0]           tap_count;
    logic [DAMP_W-1:0]             damp_gain;
    logic signed [SAMPLE_BITS-1:0] feedback_gain;
    logic [GAIN_W-1:0]             left_gain;
    logic [GAIN_W-1:0]             right_gain;
  } cfg_t;

  typedef struct packed {
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic [TAP_AW-1:0]             coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic signed [SAMPLE_BITS-1:0] left_out;
  } res_t;

endpackage

`default_nettype wire

### rtl/fcdf_ram.sv
`default_nettype none

module fcdf_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 24,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/fcdf_core.sv
`default_nettype none

module fcdf_core
  import fcdf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  in_valid_i,
  input  wire item_t item_i,
  output logic       ready_o,
  input  wire logic  out_free_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam int unsigned SW = 60;
  localparam int unsigned MW = 25;
  localparam int unsigned PW = 2 * MW;

  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (SAMPLE_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
  localparam logic signed [SW-1:0] HALF15 = SW'(1) <<< 15;
  localparam logic signed [SW-1:0] HALF22 = SW'(1) <<< 22;
  localparam logic signed [SW-1:0] HALFC  = SW'(1) <<< (COEF_BITS - 5);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DAMP,
    ST_DAMP_WR,
    ST_FIR,
    ST_DRAIN,
    ST_RND,
    ST_FB,
    ST_LEFT,
    ST_RIGHT,
    ST_OUT
  } state_e;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > SMAX) begin
      r = SMAX;
    end else if (v < SMIN) begin
      r = SMIN;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  state_e state_q, state_d;
  logic [TAP_AW-1:0] clr_q, clr_d;
  logic [TAP_AW-1:0] wp_q, wp_d;
  logic [TAP_AW-1:0] j_q, j_d;
  logic [TAP_AW-1:0] hptr_q, hptr_d;
  logic rv_q, rv_d;
  logic pv_q, pv_d;
  logic signed [SAMPLE_BITS-1:0] damped_q, damped_d;
  logic signed [SAMPLE_BITS-1:0] fb_q, fb_d;

  logic signed [SAMPLE_BITS-1:0] sum_q;
  logic signed [SAMPLE_BITS-1:0] fir_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] acc_q;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic prod_en;

  logic [COEF_BITS-1:0]   coef_rd;
  logic [SAMPLE_BITS-1:0] hist_rd;
  logic                   coef_we, hist_we;
  logic [TAP_AW-1:0]      coef_waddr, hist_waddr;
  logic [COEF_BITS-1:0]   coef_wdata;
  logic [SAMPLE_BITS-1:0] hist_wdata;

  logic                          take;
  logic signed [SAMPLE_BITS+1:0] sum_raw;
  logic signed [SAMPLE_BITS-1:0] sum_new;
  logic [DAMP_W-1:0]             g;
  logic signed [MW-1:0]          diff;
  logic signed [SAMPLE_BITS-1:0] damped_new;
  logic signed [SAMPLE_BITS-1:0] fir_new;
  logic signed [SAMPLE_BITS-1:0] prod_r16;
  logic signed [SAMPLE_BITS-1:0] prod_r23;

  assign ready_o = (state_q == ST_IDLE);
  assign take    = ready_o && in_valid_i;

  assign sum_raw = (SAMPLE_BITS + 2)'($signed(item_i.left_sample))
                 + (SAMPLE_BITS + 2)'($signed(item_i.right_sample))
                 + (SAMPLE_BITS + 2)'(fb_q);
  assign sum_new = sat(SW'(sum_raw));

  // d*(1-g) + s*g == d + (s-d)*g, one product
  assign g    = (cfg_i.damp_gain > DAMP_ONE) ? DAMP_ONE : cfg_i.damp_gain;
  assign diff = MW'(sum_q) - MW'(damped_q);

  assign damped_new = sat(((SW'(damped_q) <<< 16) + SW'(prod_q) + HALF15) >>> 16);
  assign fir_new    = sat((acc_q + HALFC) >>> (COEF_BITS - 4));
  assign prod_r16   = sat((SW'(prod_q) + HALF15) >>> 16);
  assign prod_r23   = sat((SW'(prod_q) + HALF22) >>> 23);

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wp_d        = wp_q;
    j_d         = j_q;
    hptr_d      = hptr_q;
    rv_d        = 1'b0;
    pv_d        = rv_q;
    damped_d    = damped_q;
    fb_d        = fb_q;
    res_valid_o = 1'b0;
    prod_en     = rv_q;
    mul_a       = MW'($signed(coef_rd));
    mul_b       = MW'($signed(hist_rd));
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == TAP_AW'(MAX_TAPS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take && item_i.func == FUNC_SAMPLE) begin
          state_d = ST_DAMP;
        end
      end
      ST_DAMP: begin
        mul_a   = diff;
        mul_b   = $signed({(MW - DAMP_W)'(0), g});
        prod_en = 1'b1;
        state_d = ST_DAMP_WR;
      end
      ST_DAMP_WR: begin
        damped_d = damped_new;
        j_d      = '0;
        hptr_d   = wp_q - 1'b1;
        state_d  = (cfg_i.tap_count == '0) ? ST_RND : ST_FIR;
      end
      ST_FIR: begin
        rv_d   = 1'b1;
        j_d    = j_q + 1'b1;
        hptr_d = hptr_q - 1'b1;
        if (j_q == cfg_i.tap_count - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rv_q && !pv_q) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        state_d = ST_FB;
      end
      ST_FB: begin
        mul_a   = MW'(fir_q);
        mul_b   = MW'(cfg_i.feedback_gain);
        prod_en = 1'b1;
        state_d = ST_LEFT;
      end
      ST_LEFT: begin
        fb_d    = prod_r23;
        mul_a   = MW'(fir_q);
        mul_b   = $signed({(MW - GAIN_W)'(0), cfg_i.left_gain});
        prod_en = 1'b1;
        state_d = ST_RIGHT;
      end
      ST_RIGHT: begin
        mul_a   = MW'(fir_q);
        mul_b   = $signed({(MW - GAIN_W)'(0), cfg_i.right_gain});
        prod_en = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          wp_d        = wp_q + 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign res_o.left_out  = left_q;
  assign res_o.right_out = prod_r16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      wp_q     <= '0;
      j_q      <= '0;
      hptr_q   <= '0;
      rv_q     <= 1'b0;
      pv_q     <= 1'b0;
      damped_q <= '0;
      fb_q     <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      wp_q     <= wp_d;
      j_q      <= j_d;
      hptr_q   <= hptr_d;
      rv_q     <= rv_d;
      pv_q     <= pv_d;
      damped_q <= damped_d;
      fb_q     <= fb_d;
    end
  end

  // accumulator cannot overflow: 4095 taps of 48-bit products fit in 60 bits
  always_ff @(posedge clk_i) begin
    if (take) begin
      sum_q <= sum_new;
    end
    if (prod_en) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_DAMP_WR) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + SW'(prod_q);
    end
    if (state_q == ST_RND) begin
      fir_q <= fir_new;
    end
    if (state_q == ST_RIGHT) begin
      left_q <= prod_r16;
    end
  end

  // coefficients change only while idle or in the reset clear pass; the FIR never reads the entry at wp
  assign coef_we    = (state_q == ST_CLEAR) || (take && item_i.func == FUNC_COEF);
  assign coef_waddr = (state_q == ST_CLEAR) ? clr_q : item_i.coef_index;
  assign coef_wdata = (state_q == ST_CLEAR) ? '0 : item_i.coef_value;

  assign hist_we    = (state_q == ST_CLEAR) || (state_q == ST_DAMP_WR);
  assign hist_waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
  assign hist_wdata = (state_q == ST_CLEAR) ? '0 : damped_new;

  fcdf_ram #(
    .DEPTH(MAX_TAPS),
    .WIDTH(COEF_BITS)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(coef_wdata),
    .raddr_i(j_q),
    .rdata_o(coef_rd)
  );

  fcdf_ram #(
    .DEPTH(MAX_TAPS),
    .WIDTH(SAMPLE_BITS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hptr_q),
    .rdata_o(hist_rd)
  );

endmodule

`default_nettype wire

### rtl/fir_convolver_with_damping_feedback.sv
// Sample transaction: damping, then one coefficient/history memory read and
// multiply-accumulate per tap (none when tap_count is 0), rounding, feedback and the
// left and right gains; no new transaction is taken until the result is in the m_axis register.
// Coefficient transaction: written in the accept cycle, next transaction in the next cycle.
// Reset: a clear pass zeroes all 4096 history and coefficient entries, s_axis_tready low.
`default_nettype none

module fir_convolver_with_damping_feedback
  import fcdf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // left_sample[23:0], right_sample[47:24], coef_index[59:48], coef_value[83:60]
  input  wire logic [87:0]       s_axis_tdata,
  // func[0]
  input  wire logic              s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // left_out[23:0], right_out[47:24]
  output logic [47:0]            m_axis_tdata,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_index_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t item;
  res_t  res;
  res_t  m_data_q;
  logic  m_valid_q;
  logic  core_ready;
  logic  res_valid;
  logic  out_free;

  assign item.func         = s_axis_tuser;
  assign item.left_sample  = s_axis_tdata[23:0];
  assign item.right_sample = s_axis_tdata[47:24];
  assign item.coef_index   = s_axis_tdata[59:48];
  assign item.coef_value   = s_axis_tdata[83:60];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_count     <= TAP_COUNT_RST;
      cfg_q.damp_gain     <= DAMP_GAIN_RST;
      cfg_q.feedback_gain <= '0;
      cfg_q.left_gain     <= GAIN_RST;
      cfg_q.right_gain    <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TAP_COUNT:     cfg_q.tap_count     <= cfg_data_i[TAPCNT_W-1:0];
        CFG_DAMP_GAIN:     cfg_q.damp_gain     <= cfg_data_i[DAMP_W-1:0];
        CFG_FEEDBACK_GAIN: cfg_q.feedback_gain <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_LEFT_GAIN:     cfg_q.left_gain     <= cfg_data_i[GAIN_W-1:0];
        CFG_RIGHT_GAIN:    cfg_q.right_gain    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  fcdf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .item_i     (item),
    .ready_o    (core_ready),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= res;
    end
  end

  assign s_axis_tready = core_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

### rtl/fcdf_checker.sv
`default_nettype none

module fcdf_checker
  import fcdf_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  logic s_take;
  assign s_take = s_axis_tvalid && s_axis_tready;

  a_sample_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_take && s_axis_tuser == FUNC_SAMPLE) |=> !s_axis_tready)
    else $error("input still ready after sample transaction");

  a_coef_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_take && s_axis_tuser == FUNC_COEF) |=> s_axis_tready)
    else $error("coefficient transaction dropped ready");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output transaction changed");

endmodule

bind fir_convolver_with_damping_feedback fcdf_checker u_fcdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
